// ===== rtl/der_ecdsa_signature_to_raw_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the DER signature to raw r||s converter
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef DER_ECDSA_SIGNATURE_TO_RAW_DEFINES_SVH
`define DER_ECDSA_SIGNATURE_TO_RAW_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define D2R_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define D2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/der2raw_pkg.sv =====
// ----------------------------------------------------------------------------
// der2raw_pkg
// Types and constants of the DER signature to raw r||s converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package der2raw_pkg;

  // Default size of one half (r or s) in bytes
  localparam int HALF_BYTES_DEF = 32;

  localparam int WORD_BITS = 64;

  // DER codes
  localparam logic [7:0] SEQ_TAG      = 8'h30;
  localparam logic [7:0] INT_TAG      = 8'h02;
  localparam logic [7:0] LEN_LONG_BIT = 8'h80;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [7:0] LEN_ONE_BYTE = 8'h01;

  // Byte counter limits
  localparam logic [6:0] COUNT_MAX = 7'd127;
  localparam logic [6:0] MIN_TOTAL = 7'd8;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SEQ_TAG  = 3'd0,
    PH_SEQ_LEN  = 3'd1,
    PH_LONG_LEN = 3'd2,
    PH_INT_TAG  = 3'd3,
    PH_INT_LEN  = 3'd4,
    PH_INT_VAL  = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/der2raw_byte_if.sv =====
// ----------------------------------------------------------------------------
// der2raw_byte_if
// Byte channel carrying one DER signature byte and its last-byte mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface der2raw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/der2raw_word_if.sv =====
// ----------------------------------------------------------------------------
// der2raw_word_if
// Result channel carrying one 64-bit word of the raw r||s signature.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface der2raw_word_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  word_index;
  logic [63:0] raw_word;
  logic        final_word;

  modport source (output valid, output ok, output word_index, output raw_word,
                  output final_word, input ready);
  modport sink (input valid, input ok, input word_index, input raw_word,
                input final_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/der_ecdsa_signature_to_raw.sv =====
// ----------------------------------------------------------------------------
// der_ecdsa_signature_to_raw
// Parses a DER ECDSA signature byte by byte and emits raw r||s words.
// ----------------------------------------------------------------------------
// Usage:
//   der : byte channel, one signature byte per item, last_byte closes it.
//   raw : result channel. A rejected signature gives one item with ok=0,
//         raw_word=0, final_word=1. An accepted one gives NUM_WORDS items
//         (8 for 32-byte halves), word_index 0 up, final_word on the last.
//   Bytes are taken one per cycle while der ready is high; the parser state
//   and the r||s buffer are updated in the cycle the byte is accepted. The
//   finished signature is registered into the output buffer, then words
//   leave one per cycle while raw ready is high. Results drain from a
//   separate output buffer, so bytes of the next signature keep flowing
//   while words are delivered. If a last byte arrives while that buffer is
//   still busy, the finished buffer is parked and der ready drops until the
//   buffer frees up. A receiver stall holds the current word; only the
//   parked case above back-pressures the byte channel.
//   rst (synchronous) clears the parser, the buffer and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "der_ecdsa_signature_to_raw_defines.svh"

module der_ecdsa_signature_to_raw #(
  parameter int HALF_BYTES = der2raw_pkg::HALF_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  der2raw_byte_if.sink       der,
  der2raw_word_if.source     raw
);

  localparam int RAW_BYTES  = 2 * HALF_BYTES;
  localparam int STORE_BITS = RAW_BYTES * 8;
  localparam int HALF_BITS  = HALF_BYTES * 8;
  localparam int NUM_WORDS  = (RAW_BYTES + 7) / 8;
  localparam int BUF_BITS   = NUM_WORDS * der2raw_pkg::WORD_BITS;
  localparam int PAD_BITS   = BUF_BITS - STORE_BITS;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam logic [WIDX_W-1:0] LAST_WIDX   = WIDX_W'(NUM_WORDS - 1);
  localparam logic [7:0]        INT_LEN_MAX = 8'(HALF_BYTES + 1);
  localparam logic [5:0]        SIG_MAX     = 6'(HALF_BYTES);

  // Parser registers
  der2raw_pkg::phase_t   phase, phase_next;
  logic [6:0]            byte_count, byte_count_next;
  logic [7:0]            body_length, body_length_next;
  logic [5:0]            integer_remaining, integer_remaining_next;
  logic                  second_half, second_half_next;
  logic                  stripping_zeros, stripping_zeros_next;
  logic [5:0]            significant_count, significant_count_next;
  logic                  failed, failed_next;
  logic [STORE_BITS-1:0] store, store_next;
  logic                  ok_next;

  // Parked result while the output buffer is busy
  logic                  hold;
  logic                  ok_hold;

  // Output buffer
  logic                  obuf_valid;
  logic                  obuf_ok;
  logic [BUF_BITS-1:0]   obuf;
  logic [WIDX_W-1:0]     widx;
  logic                  obuf_last;
  logic                  obuf_free;
  logic                  in_fire;
  logic                  out_fire;

  assign in_fire   = der.valid && der.ready;
  assign out_fire  = raw.valid && raw.ready;
  assign obuf_last = !obuf_ok || (widx == LAST_WIDX);
  assign obuf_free = !obuf_valid || (raw.ready && obuf_last);

  // Next parser state for the byte on the input
  always_comb begin
    logic [7:0] b;
    logic       skip;
    logic [5:0] sig_inc;
    b                      = der.data_byte;
    skip                   = 1'b0;
    sig_inc                = significant_count + 6'd1;
    phase_next             = phase;
    byte_count_next        = (byte_count < der2raw_pkg::COUNT_MAX) ?
                             byte_count + 7'd1 : byte_count;
    body_length_next       = body_length;
    integer_remaining_next = integer_remaining;
    second_half_next       = second_half;
    stripping_zeros_next   = stripping_zeros;
    significant_count_next = significant_count;
    failed_next            = failed;
    store_next             = store;

    if (!failed) begin
      // Count down the body once inside the SEQUENCE
      if (phase >= der2raw_pkg::PH_INT_TAG) begin
        if (body_length == 8'd0) begin
          failed_next = 1'b1;
          skip        = 1'b1;
        end else begin
          body_length_next = body_length - 8'd1;
        end
      end
      if (!skip) begin
        case (phase)
          der2raw_pkg::PH_SEQ_TAG: begin
            if (b != der2raw_pkg::SEQ_TAG) failed_next = 1'b1;
            else phase_next = der2raw_pkg::PH_SEQ_LEN;
          end
          der2raw_pkg::PH_SEQ_LEN: begin
            if ((b & der2raw_pkg::LEN_LONG_BIT) != 8'd0) begin
              if ((b & der2raw_pkg::LEN_MASK) != der2raw_pkg::LEN_ONE_BYTE) begin
                failed_next = 1'b1;
              end else begin
                phase_next = der2raw_pkg::PH_LONG_LEN;
              end
            end else begin
              body_length_next = b;
              phase_next       = der2raw_pkg::PH_INT_TAG;
            end
          end
          der2raw_pkg::PH_LONG_LEN: begin
            body_length_next = b;
            phase_next       = der2raw_pkg::PH_INT_TAG;
          end
          der2raw_pkg::PH_INT_TAG: begin
            if (b != der2raw_pkg::INT_TAG) failed_next = 1'b1;
            else phase_next = der2raw_pkg::PH_INT_LEN;
          end
          der2raw_pkg::PH_INT_LEN: begin
            if (b == 8'd0 || b > INT_LEN_MAX) begin
              failed_next = 1'b1;
            end else begin
              integer_remaining_next = b[5:0];
              stripping_zeros_next   = 1'b1;
              significant_count_next = 6'd0;
              phase_next             = der2raw_pkg::PH_INT_VAL;
            end
          end
          der2raw_pkg::PH_INT_VAL: begin
            if (!(stripping_zeros && b == 8'd0)) begin
              stripping_zeros_next   = 1'b0;
              significant_count_next = sig_inc;
              if (sig_inc > SIG_MAX) begin
                failed_next = 1'b1;
                skip        = 1'b1;
              end else if (second_half) begin
                store_next[HALF_BITS-1:0] = {store[HALF_BITS-9:0], b};
              end else begin
                store_next[STORE_BITS-1:HALF_BITS] =
                  {store[STORE_BITS-9:HALF_BITS], b};
              end
            end
            if (!skip) begin
              integer_remaining_next = integer_remaining - 6'd1;
              if (integer_remaining == 6'd1) begin
                if (second_half) begin
                  phase_next = der2raw_pkg::PH_DONE;
                end else begin
                  second_half_next = 1'b1;
                  phase_next       = der2raw_pkg::PH_INT_TAG;
                end
              end
            end
          end
          default: failed_next = 1'b1;
        endcase
      end
    end

    ok_next = !failed_next && (phase_next == der2raw_pkg::PH_DONE) &&
              (body_length_next == 8'd0) && (byte_count_next >= der2raw_pkg::MIN_TOTAL);
  end

  // Parser registers: advance per byte, clear at signature end
  always_ff @(posedge clk) begin
    if (rst || (in_fire && der.last_byte)) begin
      phase             <= der2raw_pkg::PH_SEQ_TAG;
      byte_count        <= 7'd0;
      body_length       <= 8'd0;
      integer_remaining <= 6'd0;
      second_half       <= 1'b0;
      stripping_zeros   <= 1'b0;
      significant_count <= 6'd0;
      failed            <= 1'b0;
    end else if (in_fire) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      body_length       <= body_length_next;
      integer_remaining <= integer_remaining_next;
      second_half       <= second_half_next;
      stripping_zeros   <= stripping_zeros_next;
      significant_count <= significant_count_next;
      failed            <= failed_next;
    end
  end

  // Buffer and park: keep the finished buffer if the output is busy
  always_ff @(posedge clk) begin
    if (rst) begin
      store   <= '0;
      hold    <= 1'b0;
      ok_hold <= 1'b0;
    end else if (in_fire) begin
      if (der.last_byte) begin
        store   <= obuf_free ? '0 : store_next;
        hold    <= !obuf_free;
        ok_hold <= ok_next;
      end else begin
        store <= store_next;
      end
    end else if (hold && obuf_free) begin
      store <= '0;
      hold  <= 1'b0;
    end
  end

  // Output buffer: load a finished signature, shift out one word per item
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      obuf_ok    <= 1'b0;
      obuf       <= '0;
      widx       <= '0;
    end else if (in_fire && der.last_byte && obuf_free) begin
      obuf_valid <= 1'b1;
      obuf_ok    <= ok_next;
      obuf       <= ok_next ? (BUF_BITS'(store_next) << PAD_BITS) : '0;
      widx       <= '0;
    end else if (hold && obuf_free) begin
      obuf_valid <= 1'b1;
      obuf_ok    <= ok_hold;
      obuf       <= ok_hold ? (BUF_BITS'(store) << PAD_BITS) : '0;
      widx       <= '0;
    end else if (out_fire) begin
      if (obuf_last) begin
        obuf_valid <= 1'b0;
      end else begin
        obuf <= obuf << der2raw_pkg::WORD_BITS;
        widx <= widx + WIDX_W'(1);
      end
    end
  end

  // Drive the channels
  always_comb begin
    der.ready      = !hold;
    raw.valid      = obuf_valid;
    raw.ok         = obuf_ok;
    raw.word_index = 3'(widx);
    raw.raw_word   = obuf[BUF_BITS-1 -: der2raw_pkg::WORD_BITS];
    raw.final_word = obuf_last;
  end

  // Checks
  `D2R_ASSERT_SAME(a_fail_item_shape, clk, rst, raw.valid && !raw.ok,
    raw.final_word && raw.raw_word == 64'd0 && raw.word_index == 3'd0,
    "failure item must be a single zero word")
  `D2R_ASSERT_SAME(a_hold_needs_busy, clk, rst, hold, obuf_valid,
    "parked buffer without a busy output buffer")
  `D2R_ASSERT_NEXT(a_last_loads, clk, rst, in_fire && der.last_byte,
    raw.valid && (hold || raw.word_index == 3'd0),
    "last byte did not start or park a result")
  `D2R_ASSERT_NEXT(a_word_step, clk, rst, out_fire && !raw.final_word,
    raw.valid && raw.ok && widx == $past(widx) + WIDX_W'(1),
    "word index did not advance by one")

endmodule

`default_nettype wire

// ===== test/der_ecdsa_signature_to_raw_test.sv =====
// ----------------------------------------------------------------------------
// der_ecdsa_signature_to_raw_test
// Streams DER ECDSA signatures byte by byte into the converter. The stream is
// a short directed table first, then random well-formed and damaged
// signatures. Each result word is checked field by field against a parser
// kept alongside the block, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_ecdsa_signature_to_raw_test;

  localparam int HALF        = der2raw_pkg::HALF_BYTES_DEF;
  localparam int RAW_LEN     = 2 * HALF;
  localparam int NUM_WORDS   = (RAW_LEN + 7) / 8;
  localparam int BYTE_TARGET = 210;
  localparam int WORD_TARGET = 48;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic        ok;
    logic [2:0]  word_index;
    logic [63:0] raw_word;
    logic        final_word;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       reject_expected;
  } der_row_t;

  typedef enum int {
    FLAW_NONE, FLAW_FLIP, FLAW_CUT, FLAW_TRAIL_IN, FLAW_TRAIL_OUT,
    FLAW_BAD_LEN, FLAW_INT_LEN, FLAW_WIDE_VALUE, FLAW_NOISE
  } flaw_t;

  localparam raw_item_t REJECT_ITEM = '{1'b0, 3'd0, 64'd0, 1'b1};
  localparam logic [7:0] LEN_LONG_ONE =
    der2raw_pkg::LEN_LONG_BIT | der2raw_pkg::LEN_ONE_BYTE;

  // Directed signatures; reject rows carry their expected result inline
  localparam int DIRECTED_ROWS = 25;
  localparam der_row_t DIRECTED [DIRECTED_ROWS] = '{
    // smallest valid signature, exactly eight bytes, s all zero
    '{der2raw_pkg::SEQ_TAG, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0},
    '{der2raw_pkg::INT_TAG, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{der2raw_pkg::INT_TAG, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0},
    // long form length on a short body, r with a leading zero to drop
    '{der2raw_pkg::SEQ_TAG, 1'b0, 1'b0}, '{LEN_LONG_ONE, 1'b0, 1'b0},
    '{8'h07, 1'b0, 1'b0},
    '{der2raw_pkg::INT_TAG, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0},
    '{der2raw_pkg::INT_TAG, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h01, 1'b1, 1'b0},
    // wrong sequence tag, single byte
    '{8'hFF, 1'b1, 1'b1},
    // integer length of zero
    '{der2raw_pkg::SEQ_TAG, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0},
    '{der2raw_pkg::INT_TAG, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1},
    // long form marker with no length bytes
    '{der2raw_pkg::SEQ_TAG, 1'b0, 1'b0}, '{der2raw_pkg::LEN_LONG_BIT, 1'b1, 1'b1}
  };

  logic clk;
  logic rst;

  der2raw_byte_if der ();
  der2raw_word_if raw ();

  der_ecdsa_signature_to_raw dut (
    .clk (clk),
    .rst (rst),
    .der (der),
    .raw (raw)
  );

  // Parser state mirrored from the block
  der2raw_pkg::phase_t sig_phase;
  logic [6:0] sig_count;
  logic [7:0] sig_body;
  logic [5:0] sig_int_left;
  logic       sig_in_s;
  logic       sig_stripping;
  logic [5:0] sig_kept;
  logic       sig_reject;
  logic [7:0] sig_raw [RAW_LEN];
  raw_item_t  sig_words [NUM_WORDS];

  raw_item_t  expected_words [$];
  logic [7:0] sig_bytes [$];
  logic [7:0] body_bytes [$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int words_predicted = 0;
  int words_seen = 0;
  int sigs_parsed = 0;
  int sigs_rejected = 0;
  int input_stalls = 0;
  int burst_left = 0;
  bit hold_pending = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  task automatic clear_parser();
    sig_phase     = der2raw_pkg::PH_SEQ_TAG;
    sig_count     = '0;
    sig_body      = '0;
    sig_int_left  = '0;
    sig_in_s      = 1'b0;
    sig_stripping = 1'b0;
    sig_kept      = '0;
    sig_reject    = 1'b0;
    for (int i = 0; i < RAW_LEN; i++) sig_raw[i] = 8'h00;
  endtask

  // Advance the parser by one byte; fill sig_words on the last byte
  task automatic parse_der_byte(input logic [7:0] b, input logic last, output int n_words);
    int base;
    logic [63:0] w;
    n_words = 0;
    if (sig_count != der2raw_pkg::COUNT_MAX) sig_count++;
    if (!sig_reject) begin
      if (sig_phase >= der2raw_pkg::PH_INT_TAG && sig_body == 0) begin
        sig_reject = 1'b1;
      end else begin
        if (sig_phase >= der2raw_pkg::PH_INT_TAG) sig_body--;
        case (sig_phase)
          der2raw_pkg::PH_SEQ_TAG: begin
            if (b != der2raw_pkg::SEQ_TAG) sig_reject = 1'b1;
            else sig_phase = der2raw_pkg::PH_SEQ_LEN;
          end
          der2raw_pkg::PH_SEQ_LEN: begin
            if ((b & der2raw_pkg::LEN_LONG_BIT) != 0) begin
              if ((b & der2raw_pkg::LEN_MASK) != der2raw_pkg::LEN_ONE_BYTE)
                sig_reject = 1'b1;
              else
                sig_phase = der2raw_pkg::PH_LONG_LEN;
            end else begin
              sig_body  = b;
              sig_phase = der2raw_pkg::PH_INT_TAG;
            end
          end
          der2raw_pkg::PH_LONG_LEN: begin
            sig_body  = b;
            sig_phase = der2raw_pkg::PH_INT_TAG;
          end
          der2raw_pkg::PH_INT_TAG: begin
            if (b != der2raw_pkg::INT_TAG) sig_reject = 1'b1;
            else sig_phase = der2raw_pkg::PH_INT_LEN;
          end
          der2raw_pkg::PH_INT_LEN: begin
            if (b == 0 || b > HALF + 1) begin
              sig_reject = 1'b1;
            end else begin
              sig_int_left  = b[5:0];
              sig_stripping = 1'b1;
              sig_kept      = '0;
              sig_phase     = der2raw_pkg::PH_INT_VAL;
            end
          end
          der2raw_pkg::PH_INT_VAL: begin
            // drop leading zeros, shift kept bytes into the current half
            if (!(sig_stripping && b == 0)) begin
              sig_stripping = 1'b0;
              sig_kept++;
              if (sig_kept > HALF) begin
                sig_reject = 1'b1;
              end else begin
                base = sig_in_s ? HALF : 0;
                for (int i = 0; i < HALF - 1; i++) sig_raw[base + i] = sig_raw[base + i + 1];
                sig_raw[base + HALF - 1] = b;
              end
            end
            if (!sig_reject) begin
              sig_int_left--;
              if (sig_int_left == 0) begin
                if (sig_in_s) begin
                  sig_phase = der2raw_pkg::PH_DONE;
                end else begin
                  sig_in_s  = 1'b1;
                  sig_phase = der2raw_pkg::PH_INT_TAG;
                end
              end
            end
          end
          default: sig_reject = 1'b1;
        endcase
      end
    end
    if (last) begin
      if (sig_reject || sig_phase != der2raw_pkg::PH_DONE || sig_body != 0 ||
          sig_count < der2raw_pkg::MIN_TOTAL) begin
        sig_words[0] = REJECT_ITEM;
        n_words = 1;
        sigs_rejected++;
      end else begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          w = '0;
          for (int j = 0; j < 8; j++) w = {w[55:0], sig_raw[k * 8 + j]};
          sig_words[k] = '{1'b1, k[2:0], w, (k == NUM_WORDS - 1)};
        end
        n_words = NUM_WORDS;
        sigs_parsed++;
      end
      clear_parser();
    end
  endtask

  // Offer one byte in bursts with random gaps; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed_reject);
    int gap;
    int n_words;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        der.valid     <= 1'b0;
        der.data_byte <= 8'($urandom);
        der.last_byte <= 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    der.valid     <= 1'b1;
    der.data_byte <= b;
    der.last_byte <= last;
    @(posedge clk);
    while (!der.ready) @(posedge clk);
    bytes_sent++;
    parse_der_byte(b, last, n_words);
    if (typed_reject) begin
      expected_words.push_back(REJECT_ITEM);
      words_predicted++;
    end else begin
      for (int k = 0; k < n_words; k++) expected_words.push_back(sig_words[k]);
      words_predicted += n_words;
    end
  endtask

  function automatic int pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(HALF - 1, HALF + 1) : $urandom_range(1, 6);
  endfunction

  // Leading zeros: mostly none, sometimes some or all; a full-width
  // value needs at least one so that it still fits
  function automatic int pick_zeros(input int len);
    int z;
    z = ($urandom_range(3) == 0) ? $urandom_range(1, len) : 0;
    if (len == HALF + 1 && z == 0) z = 1;
    return z;
  endfunction

  task automatic append_integer(input int len, input int zeros, input bit first_nonzero);
    logic [7:0] b;
    body_bytes.push_back(der2raw_pkg::INT_TAG);
    body_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      b = (i < zeros) ? 8'h00 : 8'($urandom_range(255));
      if (first_nonzero && i == 0) b = 8'($urandom_range(1, 255));
      body_bytes.push_back(b);
    end
  endtask

  // Build one signature into sig_bytes, well formed or with one flaw
  task automatic build_signature();
    flaw_t flaw;
    int r_len, s_len, r_zeros, s_zeros, hdr_len, cut, v;
    bit wide;
    body_bytes.delete();
    sig_bytes.delete();
    flaw = ($urandom_range(9) < 7) ? FLAW_NONE : flaw_t'($urandom_range(1, 8));
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 12)) sig_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) sig_bytes[0] = der2raw_pkg::SEQ_TAG;
    end else begin
      wide    = (flaw == FLAW_WIDE_VALUE);
      r_len   = wide ? HALF + 1 : pick_len();
      r_zeros = wide ? 0 : pick_zeros(r_len);
      s_len   = pick_len();
      s_zeros = pick_zeros(s_len);
      append_integer(r_len, r_zeros, wide);
      append_integer(s_len, s_zeros, 1'b0);
      if (flaw == FLAW_TRAIL_IN)
        repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(255)));
      // header in short or long form
      sig_bytes.push_back(der2raw_pkg::SEQ_TAG);
      if ($urandom_range(1)) sig_bytes.push_back(LEN_LONG_ONE);
      sig_bytes.push_back(8'(body_bytes.size()));
      hdr_len = sig_bytes.size();
      foreach (body_bytes[i]) sig_bytes.push_back(body_bytes[i]);
      case (flaw)
        FLAW_FLIP: sig_bytes[$urandom_range(sig_bytes.size() - 1)] = 8'($urandom_range(255));
        FLAW_CUT: begin
          cut = $urandom_range(1, sig_bytes.size() - 1);
          while (sig_bytes.size() > cut) void'(sig_bytes.pop_back());
        end
        FLAW_TRAIL_OUT:
          repeat ($urandom_range(1, 3)) sig_bytes.push_back(8'($urandom_range(255)));
        FLAW_BAD_LEN: begin
          v = $urandom_range(126);
          if (v == 1) v = 0;
          sig_bytes[1] = der2raw_pkg::LEN_LONG_BIT | 8'(v);
        end
        FLAW_INT_LEN:
          sig_bytes[hdr_len + 1] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(HALF + 2, 255));
        default: ;
      endcase
    end
  endtask

  // Receiver: random stall rate per stretch, plus one long hold-off
  initial begin : drain_words
    int stretch;
    int pct;
    raw.ready = 1'b0;
    forever begin
      stretch = $urandom_range(20, 120);
      case ($urandom_range(3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 80;
      endcase
      repeat (stretch) begin
        @(negedge clk);
        if (hold_pending) begin
          raw.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_pending = 0;
        end else begin
          raw.ready <= ($urandom_range(99) >= pct);
        end
      end
    end
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk) begin : watch_words
    raw_item_t got;
    raw_item_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_words.size());
      $display("Some tests failed");
      $finish;
    end else begin
      if (!rst && der.valid && !der.ready) input_stalls++;
      if (!rst && raw.valid && raw.ready) begin
        got = '{raw.ok, raw.word_index, raw.raw_word, raw.final_word};
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word ok=%0b index=%0d data=%h",
                                    got.ok, got.word_index, got.raw_word));
        end else begin
          want = expected_words.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("word %0d ok %0b, wanted %0b",
                                      words_seen, got.ok, want.ok));
          if (got.word_index !== want.word_index)
            report_mismatch($sformatf("word %0d index %0d, wanted %0d",
                                      words_seen, got.word_index, want.word_index));
          if (got.raw_word !== want.raw_word)
            report_mismatch($sformatf("word %0d data %h, wanted %h",
                                      words_seen, got.raw_word, want.raw_word));
          if (got.final_word !== want.final_word)
            report_mismatch($sformatf("word %0d final %0b, wanted %0b",
                                      words_seen, got.final_word, want.final_word));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    rst           = 1'b1;
    der.valid     = 1'b0;
    der.data_byte = 8'h00;
    der.last_byte = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data_byte, DIRECTED[i].last_byte, DIRECTED[i].reject_expected);

    // Random signatures; hold the receiver off early so the block backs up
    hold_pending = 1;
    while (bytes_sent < BYTE_TARGET || words_predicted < WORD_TARGET) begin
      build_signature();
      foreach (sig_bytes[i]) send_byte(sig_bytes[i], i == sig_bytes.size() - 1, 1'b0);
    end

    @(negedge clk);
    der.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes over %0d signatures: %0d parsed, %0d rejected.",
             bytes_sent, sigs_parsed + sigs_rejected, sigs_parsed, sigs_rejected);
    $display("Checked %0d result words; byte input held off for %0d cycles.",
             words_seen, input_stalls);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
